>>> sv/lbs_pkg.sv
// ----------------------------------------------------------------------------
// lbs_pkg: shared types and constants for the 2D linear blend skinning unit
// Bone table geometry, field codes and the controller-to-datapath command.
// ----------------------------------------------------------------------------
`default_nettype none
package lbs_pkg;
   localparam int BONE_COUNT = 64;
   localparam int BONE_AW    = (BONE_COUNT > 1) ? $clog2(BONE_COUNT) : 1;

   localparam logic [2:0] FLD_A  = 3'd0;
   localparam logic [2:0] FLD_B  = 3'd1;
   localparam logic [2:0] FLD_C  = 3'd2;
   localparam logic [2:0] FLD_D  = 3'd3;
   localparam logic [2:0] FLD_TX = 3'd4;
   localparam logic [2:0] FLD_TY = 3'd5;

   localparam logic OP_LOAD  = 1'b0;
   localparam logic OP_BLEND = 1'b1;

   localparam logic [16:0] WEIGHT_ONE = 17'd65536;

   // datapath command, one phase per cycle of an influence
   typedef struct packed {
      logic capture;   // latch input item, start bone read
      logic multiply;  // form matrix products
      logic weigh;     // form term * weight
      logic accum;     // add into sums
      logic emit;      // present result, clear sums
   } lbs_cmd_type;
endpackage
`default_nettype wire

>>> sv/lbs_ram.sv
// ----------------------------------------------------------------------------
// lbs_ram: generic single-port-write, single-read RAM
// Registered read data, no reset on contents.
// ----------------------------------------------------------------------------
`default_nettype none
module lbs_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end
endmodule
`default_nettype wire

>>> sv/lbs_datapath.sv
// ----------------------------------------------------------------------------
// lbs_datapath: bone table, products, weighting and accumulation
// Steps through one influence under control of the command from lbs_ctrl.
// ----------------------------------------------------------------------------
`default_nettype none
module lbs_datapath import lbs_pkg::*; (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire lbs_cmd_type        cmd,
   input  wire logic               load_en,
   input  wire logic [BONE_AW-1:0] bone_index,
   input  wire logic [2:0]         field_select,
   input  wire logic signed [31:0] load_value,
   input  wire logic signed [31:0] local_x,
   input  wire logic signed [31:0] local_y,
   input  wire logic signed [31:0] deform_x,
   input  wire logic signed [31:0] deform_y,
   input  wire logic [16:0]        weight,
   input  wire logic signed [31:0] origin_x,
   input  wire logic signed [31:0] origin_y,
   output logic signed [31:0]      world_x,
   output logic signed [31:0]      world_y,
   output logic                    saturated
);
   localparam logic signed [47:0] S48_MAX = {1'b0, {47{1'b1}}};
   localparam logic signed [47:0] S48_MIN = {1'b1, {47{1'b0}}};

   logic [31:0] ra, rb, rc, rd, rtx, rty;
   logic [5:0]  wsel;

   always_comb begin
      wsel = '0;
      if (load_en) begin
         unique case (field_select)
            FLD_A:   wsel[0] = 1'b1;
            FLD_B:   wsel[1] = 1'b1;
            FLD_C:   wsel[2] = 1'b1;
            FLD_D:   wsel[3] = 1'b1;
            FLD_TX:  wsel[4] = 1'b1;
            FLD_TY:  wsel[5] = 1'b1;
            default: wsel    = '0;
         endcase
      end
   end

   lbs_ram #(.WIDTH(32), .DEPTH(BONE_COUNT)) u_a (.clock, .wr_en(wsel[0]),
      .wr_addr(bone_index), .wr_data(load_value), .rd_addr(bone_index), .rd_data(ra));
   lbs_ram #(.WIDTH(32), .DEPTH(BONE_COUNT)) u_b (.clock, .wr_en(wsel[1]),
      .wr_addr(bone_index), .wr_data(load_value), .rd_addr(bone_index), .rd_data(rb));
   lbs_ram #(.WIDTH(32), .DEPTH(BONE_COUNT)) u_c (.clock, .wr_en(wsel[2]),
      .wr_addr(bone_index), .wr_data(load_value), .rd_addr(bone_index), .rd_data(rc));
   lbs_ram #(.WIDTH(32), .DEPTH(BONE_COUNT)) u_d (.clock, .wr_en(wsel[3]),
      .wr_addr(bone_index), .wr_data(load_value), .rd_addr(bone_index), .rd_data(rd));
   lbs_ram #(.WIDTH(32), .DEPTH(BONE_COUNT)) u_tx (.clock, .wr_en(wsel[4]),
      .wr_addr(bone_index), .wr_data(load_value), .rd_addr(bone_index), .rd_data(rtx));
   lbs_ram #(.WIDTH(32), .DEPTH(BONE_COUNT)) u_ty (.clock, .wr_en(wsel[5]),
      .wr_addr(bone_index), .wr_data(load_value), .rd_addr(bone_index), .rd_data(rty));

   // stage registers
   logic signed [31:0] vx_ff, vy_ff;
   logic [16:0]        w_ff;
   logic signed [63:0] pa_ff, pb_ff, pc_ff, pd_ff;
   logic signed [31:0] tx_ff, ty_ff;
   logic signed [47:0] ex_ff, ey_ff;
   logic signed [47:0] sum_x_ff, sum_y_ff;

   function automatic logic signed [31:0] sat32(input logic signed [32:0] v);
      if (v > 33'sh0_7FFF_FFFF) return 32'sh7FFF_FFFF;
      if (v < -33'sh0_8000_0000) return 32'sh8000_0000;
      return v[31:0];
   endfunction

   function automatic logic signed [47:0] sat48(input logic signed [49:0] v);
      if (v > 50'(S48_MAX)) return S48_MAX;
      if (v < 50'(S48_MIN)) return S48_MIN;
      return v[47:0];
   endfunction

   logic signed [49:0] term_x, term_y;
   logic signed [47:0] tcx, tcy;
   logic signed [65:0] wx_prod, wy_prod;
   logic signed [49:0] acc_x, acc_y;
   logic signed [48:0] out_x, out_y;

   always_comb begin
      // arithmetic shift is floor
      term_x = 50'(tx_ff) + 50'(pa_ff >>> 16) + 50'(pb_ff >>> 16);
      term_y = 50'(ty_ff) + 50'(pc_ff >>> 16) + 50'(pd_ff >>> 16);
      tcx = sat48(term_x);
      tcy = sat48(term_y);
      // weight is unsigned: widen with a zero sign bit
      wx_prod = tcx * $signed({1'b0, w_ff});
      wy_prod = tcy * $signed({1'b0, w_ff});
      acc_x = 50'(sum_x_ff) + 50'(ex_ff);
      acc_y = 50'(sum_y_ff) + 50'(ey_ff);
      out_x = 49'(sum_x_ff) + 49'(origin_x);
      out_y = 49'(sum_y_ff) + 49'(origin_y);
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         vx_ff <= sat32(33'(local_x) + 33'(deform_x));
         vy_ff <= sat32(33'(local_y) + 33'(deform_y));
         w_ff  <= (weight > WEIGHT_ONE) ? WEIGHT_ONE : weight;
      end
      if (cmd.multiply) begin
         pa_ff <= $signed(ra) * vx_ff;
         pb_ff <= $signed(rb) * vy_ff;
         pc_ff <= $signed(rc) * vx_ff;
         pd_ff <= $signed(rd) * vy_ff;
         tx_ff <= $signed(rtx);
         ty_ff <= $signed(rty);
      end
      if (cmd.weigh) begin
         ex_ff <= 48'(wx_prod >>> 16);
         ey_ff <= 48'(wy_prod >>> 16);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sum_x_ff <= '0;
         sum_y_ff <= '0;
      end else if (cmd.emit) begin
         sum_x_ff <= '0;
         sum_y_ff <= '0;
      end else if (cmd.accum) begin
         sum_x_ff <= sat48(acc_x);
         sum_y_ff <= sat48(acc_y);
      end
   end

   logic sat_x, sat_y;
   always_comb begin
      sat_x = (out_x > 49'sh0_7FFF_FFFF) || (out_x < -49'sh0_8000_0000);
      sat_y = (out_y > 49'sh0_7FFF_FFFF) || (out_y < -49'sh0_8000_0000);
      world_x = sat_x ? (out_x[48] ? 32'sh8000_0000 : 32'sh7FFF_FFFF) : out_x[31:0];
      world_y = sat_y ? (out_y[48] ? 32'sh8000_0000 : 32'sh7FFF_FFFF) : out_y[31:0];
      saturated = sat_x || sat_y;
   end
endmodule
`default_nettype wire

>>> sv/lbs_ctrl.sv
// ----------------------------------------------------------------------------
// lbs_ctrl: sequencer for the skinning datapath
// Accepts one transaction, steps its phases, signals the result capture.
// ----------------------------------------------------------------------------
`default_nettype none
module lbs_ctrl import lbs_pkg::*; (
   input  wire logic   clock,
   input  wire logic   reset,
   input  wire logic   in_valid,
   input  wire logic   in_op,
   input  wire logic   in_last,
   output logic        in_ready,
   output logic        load_en,
   output lbs_cmd_type cmd,
   output logic        out_capture,
   input  wire logic   out_busy
);
   typedef enum logic [2:0] {
      ST_IDLE, ST_MUL, ST_WEIGH, ST_ACC, ST_EMIT
   } state_type;

   state_type state_ff;
   logic      last_ff;

   assign in_ready = (state_ff == ST_IDLE);
   assign load_en  = in_valid && in_ready && (in_op == OP_LOAD);

   always_comb begin
      cmd = '0;
      cmd.capture  = in_valid && in_ready && (in_op == OP_BLEND);
      cmd.multiply = (state_ff == ST_MUL);
      cmd.weigh    = (state_ff == ST_WEIGH);
      cmd.accum    = (state_ff == ST_ACC);
      cmd.emit     = (state_ff == ST_EMIT) && !out_busy;
   end
   assign out_capture = cmd.emit;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         last_ff  <= 1'b0;
      end else begin
         unique case (state_ff)
            ST_IDLE: begin
               if (cmd.capture) begin
                  state_ff <= ST_MUL;
                  last_ff  <= in_last;
               end
            end
            ST_MUL:   state_ff <= ST_WEIGH;
            ST_WEIGH: state_ff <= ST_ACC;
            ST_ACC:   state_ff <= last_ff ? ST_EMIT : ST_IDLE;
            ST_EMIT: begin
               if (!out_busy) state_ff <= ST_IDLE;
            end
            default:  state_ff <= ST_IDLE;
         endcase
      end
   end
endmodule
`default_nettype wire

>>> sv/linear_blend_vertex_skinning.sv
// ----------------------------------------------------------------------------
// linear_blend_vertex_skinning: 2D linear blend skinning unit, Q16.16
// Controller, datapath and output register.
// ----------------------------------------------------------------------------
// Usage:
//   req_ channel carries load and influence transactions. A load writes one
//   field of a bone transform; an influence adds weight*(M*(v+d)+t) to the
//   running sum. tuser = op; tlast = last_influence.
//   rsp_ channel returns world_x, world_y and the saturated flag once per
//   vertex, after the influence that carries tlast.
//   An influence steps the sequencer through capture with bone read,
//   multiply, weigh and accumulate; the last one of a vertex adds an emit
//   step that moves the sum into the output register.
//   Influences take turns on the single shared multiply/accumulate datapath.
//   The output register holds one result; when the receiver stalls with it
//   full, the sequencer waits in its emit step and accepts nothing.
//   Reset clears the sums, origin registers and the output valid flag. The
//   bone table has no reset: loading a bone before use is the user's job.
//   origin_x/origin_y sit at csr_ byte addresses 0 and 4.
// ----------------------------------------------------------------------------
`default_nettype none
module linear_blend_vertex_skinning import lbs_pkg::*; (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   // tdata from bit 0: bone_index[5:0], field_select[8:6], load_value[40:9],
   // local_x[72:41], local_y[104:73], deform_x[136:105], deform_y[168:137],
   // weight[185:169], zero pad [191:186]
   input  wire logic [191:0] req_tdata,
   input  wire logic        req_tuser,   // op
   input  wire logic        req_tlast,   // last_influence
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   // tdata from bit 0: world_x[31:0], world_y[63:32]
   output logic [63:0]      rsp_tdata,
   output logic             rsp_tuser,   // saturated
   input  wire logic        csr_psel,
   input  wire logic        csr_penable,
   input  wire logic        csr_pwrite,
   input  wire logic [2:0]  csr_paddr,
   input  wire logic [31:0] csr_pwdata,
   output logic [31:0]      csr_prdata,
   output logic             csr_pready
);
   localparam logic [2:0] ADDR_ORIGIN_X = 3'd0;
   localparam logic [2:0] ADDR_ORIGIN_Y = 3'd4;

   logic signed [31:0] origin_x_ff, origin_y_ff;
   logic               csr_wr;

   assign csr_pready = 1'b1;
   assign csr_wr = csr_psel && csr_penable && csr_pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         origin_x_ff <= '0;
         origin_y_ff <= '0;
      end else if (csr_wr) begin
         if (csr_paddr == ADDR_ORIGIN_X) origin_x_ff <= csr_pwdata;
         if (csr_paddr == ADDR_ORIGIN_Y) origin_y_ff <= csr_pwdata;
      end
   end

   always_comb begin
      unique case (csr_paddr)
         ADDR_ORIGIN_X: csr_prdata = origin_x_ff;
         ADDR_ORIGIN_Y: csr_prdata = origin_y_ff;
         default:       csr_prdata = '0;
      endcase
   end

   lbs_cmd_type cmd;
   logic        load_en, out_capture;
   logic        rsp_valid_ff;
   logic [63:0] rsp_data_ff;
   logic        rsp_sat_ff;
   logic signed [31:0] world_x, world_y;
   logic        saturated;
   logic        out_busy;

   // hold the result while the receiver stalls
   assign out_busy = rsp_valid_ff && !rsp_tready;

   lbs_ctrl u_ctrl (
      .clock, .reset,
      .in_valid(req_tvalid), .in_op(req_tuser), .in_last(req_tlast),
      .in_ready(req_tready), .load_en, .cmd, .out_capture, .out_busy
   );

   lbs_datapath u_dp (
      .clock, .reset, .cmd, .load_en,
      .bone_index  (req_tdata[BONE_AW-1:0]),
      .field_select(req_tdata[8:6]),
      .load_value  (req_tdata[40:9]),
      .local_x     (req_tdata[72:41]),
      .local_y     (req_tdata[104:73]),
      .deform_x    (req_tdata[136:105]),
      .deform_y    (req_tdata[168:137]),
      .weight      (req_tdata[185:169]),
      .origin_x(origin_x_ff), .origin_y(origin_y_ff),
      .world_x, .world_y, .saturated
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_capture) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (out_capture) begin
         rsp_data_ff <= {world_y, world_x};
         rsp_sat_ff  <= saturated;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_sat_ff;

   // a new result never overwrites one that is still waiting
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      out_capture |-> !(rsp_valid_ff && !rsp_tready))
      else $error("result overwritten");
   // an influence accept is followed by a busy sequencer
   a_busy_after_blend: assert property (@(posedge clock) disable iff (reset)
      cmd.capture |=> !req_tready)
      else $error("accepted during influence");
   // loads never start the datapath
   a_load_no_cmd: assert property (@(posedge clock) disable iff (reset)
      load_en |-> !cmd.capture)
      else $error("load started datapath");
endmodule
`default_nettype wire

>>> test/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the 2D linear blend skinning unit
// Load and influence transactions are driven with random gaps, including a
// long receiver hold-off. Each accepted influence runs through a local
// fixed-point predictor. Every vertex result is compared field by field with
// the oldest expected world position.
// ----------------------------------------------------------------------------
`default_nettype none
module tb_top;
   import lbs_pkg::*;

   localparam logic [2:0] ADDR_ORIGIN_X = 3'd0;
   localparam logic [2:0] ADDR_ORIGIN_Y = 3'd4;
   localparam longint S32_MAX = 64'sh7FFF_FFFF;
   localparam longint S32_MIN = -S32_MAX - 1;
   localparam longint S48_MAX = 64'sh7FFF_FFFF_FFFF;
   localparam longint S48_MIN = -S48_MAX - 1;
   localparam int     NUM_DIRECTED = 20;
   localparam int     PHASE_ITEMS  = 220;

   // one request transaction, plus an optional hand-typed expectation
   typedef struct {
      logic        op;
      logic [5:0]  bone;
      logic [2:0]  fld;
      logic [31:0] load_val;
      logic [31:0] lx, ly, dx, dy;
      logic [16:0] w;
      logic        last;
      bit          typed;
      logic [31:0] ex, ey;
      logic        es;
   } skin_item_type;

   typedef struct {
      logic [31:0] wx, wy;
      logic        sat;
   } world_pos_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_tvalid = 1'b0, req_tuser = 1'b0, req_tlast = 1'b0;
   logic [191:0] req_tdata = '0;
   logic rsp_tready = 1'b0;
   logic csr_psel = 1'b0, csr_penable = 1'b0, csr_pwrite = 1'b0;
   logic [2:0] csr_paddr = '0;
   logic [31:0] csr_pwdata = '0;
   wire  req_tready, rsp_tvalid, rsp_tuser, csr_pready;
   wire  [63:0] rsp_tdata;
   wire  [31:0] csr_prdata;

   linear_blend_vertex_skinning u_top (
      .clock, .reset,
      .req_tvalid, .req_tready, .req_tdata, .req_tuser, .req_tlast,
      .rsp_tvalid, .rsp_tready, .rsp_tdata, .rsp_tuser,
      .csr_psel, .csr_penable, .csr_pwrite, .csr_paddr, .csr_pwdata,
      .csr_prdata, .csr_pready
   );

   always #2 clock = ~clock;

   // predictor state: bone table, running sums, origin, write tracking
   longint        bone_m[6][64];
   logic [5:0]    bone_loaded[64];
   longint        acc_x, acc_y, org_x, org_y;
   world_pos_type pending_pos[$];
   int            err_count = 0;
   bit            calm = 1'b0;       // no idling on either side while set
   bit            want_hold = 1'b0;  // ask the receiver for a long hold-off
   skin_item_type directed_tab[NUM_DIRECTED];

   function automatic longint sx32(logic [31:0] v);
      return longint'(signed'(v));
   endfunction

   function automatic longint clamp(longint v, longint lo, longint hi);
      return (v < lo) ? lo : ((v > hi) ? hi : v);
   endfunction

   // weight * (m0*vx + m1*vy + t), each product and the weighted term floored
   function automatic longint weighted_term(longint m0, longint m1, longint t,
                                            longint vx, longint vy, longint w);
      longint term;
      term = clamp(t + ((m0 * vx) >>> 16) + ((m1 * vy) >>> 16), S48_MIN, S48_MAX);
      return (term * w) >>> 16;
   endfunction

   // advance the predictor by one accepted transaction
   task automatic skin_predict(skin_item_type s);
      longint vx, vy, w, fx, fy, cx, cy;
      world_pos_type p;
      if (s.op == OP_LOAD) begin
         if (s.fld <= FLD_TY) begin
            bone_m[s.fld][s.bone] = sx32(s.load_val);
            bone_loaded[s.bone][s.fld] = 1'b1;
         end
         return;
      end
      vx = clamp(sx32(s.lx) + sx32(s.dx), S32_MIN, S32_MAX);
      vy = clamp(sx32(s.ly) + sx32(s.dy), S32_MIN, S32_MAX);
      w  = (s.w > WEIGHT_ONE) ? longint'(WEIGHT_ONE) : longint'(s.w);
      acc_x = clamp(acc_x + weighted_term(bone_m[FLD_A][s.bone], bone_m[FLD_B][s.bone],
                    bone_m[FLD_TX][s.bone], vx, vy, w), S48_MIN, S48_MAX);
      acc_y = clamp(acc_y + weighted_term(bone_m[FLD_C][s.bone], bone_m[FLD_D][s.bone],
                    bone_m[FLD_TY][s.bone], vx, vy, w), S48_MIN, S48_MAX);
      if (!s.last) return;
      fx = org_x + acc_x;
      fy = org_y + acc_y;
      cx = clamp(fx, S32_MIN, S32_MAX);
      cy = clamp(fy, S32_MIN, S32_MAX);
      acc_x = 0;
      acc_y = 0;
      if (s.typed) begin
         p.wx = s.ex; p.wy = s.ey; p.sat = s.es;
      end else begin
         p.wx = cx[31:0]; p.wy = cy[31:0]; p.sat = (cx != fx) || (cy != fy);
      end
      pending_pos.push_back(p);
   endtask

   // offer one transaction, optionally after an idle gap, and hold until taken
   task automatic drive_item(skin_item_type s);
      if (!calm && $urandom_range(99) < 35) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= s.op;
      req_tlast  <= s.last;
      req_tdata  <= {6'b0, s.w, s.dy, s.dx, s.ly, s.lx, s.load_val, s.fld, s.bone};
      do @(posedge clock); while (!req_tready);
      skin_predict(s);
   endtask

   // setup then access phase; the register takes the value in the access phase
   task automatic csr_write(logic [2:0] addr, logic [31:0] val);
      csr_psel <= 1'b1; csr_pwrite <= 1'b1; csr_penable <= 1'b0;
      csr_paddr <= addr; csr_pwdata <= val;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      csr_psel <= 1'b0; csr_penable <= 1'b0; csr_pwrite <= 1'b0;
      if (addr == ADDR_ORIGIN_X) org_x = sx32(val);
      else org_y = sx32(val);
   endtask

   // drop valid, wait for every expected vertex, then let the pipe settle
   task automatic drain;
      req_tvalid <= 1'b0;
      while (pending_pos.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   function automatic skin_item_type mk(logic op, logic [5:0] bone, logic [2:0] fld,
         logic [31:0] lv, logic [31:0] lx, logic [31:0] ly, logic [31:0] dx,
         logic [31:0] dy, logic [16:0] w, logic last, bit typed,
         logic [31:0] ex, logic [31:0] ey, logic es);
      skin_item_type s;
      s.op = op; s.bone = bone; s.fld = fld; s.load_val = lv;
      s.lx = lx; s.ly = ly; s.dx = dx; s.dy = dy; s.w = w; s.last = last;
      s.typed = typed; s.ex = ex; s.ey = ey; s.es = es;
      return s;
   endfunction

   // mostly modest Q16.16 values, sometimes the full 32-bit range
   function automatic logic [31:0] rand_q();
      if ($urandom_range(3) == 0) return $urandom();
      return 32'(signed'($urandom_range(0, 32'h0020_0000)) - 32'sh0010_0000);
   endfunction

   function automatic logic [5:0] pick_bone();
      logic [5:0] b;
      repeat (16) begin
         b = 6'($urandom_range(63));
         if (&bone_loaded[b]) return b;
      end
      return $urandom_range(1) ? 6'd63 : 6'd0;
   endfunction

   // receiver: check results, stall at random, honour hold-off requests
   initial begin : receiver
      int hold_left;
      world_pos_type e;
      hold_left = 0;
      forever begin
         @(posedge clock);
         if (rsp_tvalid && rsp_tready) begin
            if (pending_pos.size() == 0) begin
               $display("%0t: unexpected result x=%h y=%h sat=%b", $time,
                        rsp_tdata[31:0], rsp_tdata[63:32], rsp_tuser);
               err_count++;
            end else begin
               e = pending_pos.pop_front();
               if (rsp_tdata[31:0] !== e.wx) begin
                  $display("%0t: world_x expected %h actual %h", $time, e.wx,
                           rsp_tdata[31:0]);
                  err_count++;
               end
               if (rsp_tdata[63:32] !== e.wy) begin
                  $display("%0t: world_y expected %h actual %h", $time, e.wy,
                           rsp_tdata[63:32]);
                  err_count++;
               end
               if (rsp_tuser !== e.sat) begin
                  $display("%0t: saturated expected %b actual %b", $time, e.sat,
                           rsp_tuser);
                  err_count++;
               end
            end
         end
         if (want_hold) begin
            want_hold = 1'b0;
            hold_left = 400;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= calm || ($urandom_range(99) >= 35);
         end
      end
   end

   initial begin : watchdog
      #4_000_000;
      $display("TB_ERROR");
      $finish;
   end

   initial begin : stimulus
      skin_item_type s;
      int n, k;
      for (int b = 0; b < 64; b++) begin
         bone_loaded[b] = '0;
         for (int f = 0; f < 6; f++) bone_m[f][b] = 0;
      end
      acc_x = 0; acc_y = 0; org_x = 0; org_y = 0;

      // directed: identity bone 0, a bone 63 of extremes, weight and clamp cases
      directed_tab[0]  = mk(OP_LOAD, 0, FLD_A,  32'h0001_0000, 0,0,0,0, 0, 0, 0, 0,0,0);
      directed_tab[1]  = mk(OP_LOAD, 0, FLD_B,  32'h0, 0,0,0,0, 0, 0, 0, 0,0,0);
      directed_tab[2]  = mk(OP_LOAD, 0, FLD_C,  32'h0, 0,0,0,0, 0, 0, 0, 0,0,0);
      directed_tab[3]  = mk(OP_LOAD, 0, FLD_D,  32'h0001_0000, 0,0,0,0, 0, 0, 0, 0,0,0);
      directed_tab[4]  = mk(OP_LOAD, 0, FLD_TX, 32'h0, 0,0,0,0, 0, 0, 0, 0,0,0);
      directed_tab[5]  = mk(OP_LOAD, 0, FLD_TY, 32'h0, 0,0,0,0, 0, 0, 0, 0,0,0);
      // unused field select: ignored
      directed_tab[6]  = mk(OP_LOAD, 0, 3'd7, 32'hDEAD_BEEF, 0,0,0,0, 0, 0, 0, 0,0,0);
      // unweighted vertex through identity
      directed_tab[7]  = mk(OP_BLEND, 0, 0, 0, 32'h0001_0000, 32'h0002_0000, 0, 0,
                            WEIGHT_ONE, 1, 1, 32'h0001_0000, 32'h0002_0000, 0);
      // local plus deform clamps silently at both ends
      directed_tab[8]  = mk(OP_BLEND, 0, 0, 0, 32'h7FFF_FFFF, 32'h8000_0000,
                            32'h7FFF_FFFF, 32'h8000_0000, WEIGHT_ONE, 1, 1,
                            32'h7FFF_FFFF, 32'h8000_0000, 0);
      // weight above one counts as one; zero weight adds nothing
      directed_tab[9]  = mk(OP_BLEND, 0, 0, 0, 32'h0003_0000, 0, 0, 0, 17'h1FFFF, 0,
                            0, 0,0,0);
      directed_tab[10] = mk(OP_BLEND, 0, 0, 0, 32'h1234_5678, 32'h0BAD_0000, 0, 0,
                            0, 1, 1, 32'h0003_0000, 32'h0, 0);
      // load with last set gives nothing
      directed_tab[11] = mk(OP_LOAD, 0, 3'd6, 32'hFFFF_FFFF, 0,0,0,0, 0, 1, 0, 0,0,0);
      directed_tab[12] = mk(OP_LOAD, 63, FLD_A,  32'h7FFF_FFFF, 0,0,0,0, 0, 0, 0, 0,0,0);
      directed_tab[13] = mk(OP_LOAD, 63, FLD_B,  32'h7FFF_FFFF, 0,0,0,0, 0, 0, 0, 0,0,0);
      directed_tab[14] = mk(OP_LOAD, 63, FLD_C,  32'h8000_0000, 0,0,0,0, 0, 0, 0, 0,0,0);
      directed_tab[15] = mk(OP_LOAD, 63, FLD_D,  32'h8000_0000, 0,0,0,0, 0, 0, 0, 0,0,0);
      directed_tab[16] = mk(OP_LOAD, 63, FLD_TX, 32'h7FFF_FFFF, 0,0,0,0, 0, 0, 0, 0,0,0);
      directed_tab[17] = mk(OP_LOAD, 63, FLD_TY, 32'h8000_0000, 0,0,0,0, 0, 0, 0, 0,0,0);
      // extreme transform: both coordinates clamp, flag raised
      directed_tab[18] = mk(OP_BLEND, 63, 0, 0, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 0, 0,
                            WEIGHT_ONE, 1, 1, 32'h7FFF_FFFF, 32'h8000_0000, 1);
      directed_tab[19] = mk(OP_BLEND, 63, 0, 0, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 0, 0,
                            0, 1, 1, 32'h0, 32'h0, 0);

      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      for (int i = 0; i < NUM_DIRECTED; i++) drive_item(directed_tab[i]);
      drain();

      // random phases, each under its own origin setting
      for (int ph = 0; ph < 5; ph++) begin
         case (ph)
            0: begin csr_write(ADDR_ORIGIN_X, 32'h7FFF_FFFF);
                     csr_write(ADDR_ORIGIN_Y, 32'h8000_0000); end
            1: begin csr_write(ADDR_ORIGIN_X, 32'h8000_0000);
                     csr_write(ADDR_ORIGIN_Y, 32'h7FFF_FFFF); end
            4: begin csr_write(ADDR_ORIGIN_X, 32'h0);
                     csr_write(ADDR_ORIGIN_Y, 32'h0); end
            default: begin csr_write(ADDR_ORIGIN_X, rand_q());
                           csr_write(ADDR_ORIGIN_Y, rand_q()); end
         endcase
         calm = (ph == 2);
         if (ph == 1) want_hold = 1'b1;   // receiver stalls, sender keeps pushing
         n = 0;
         while (n < PHASE_ITEMS) begin
            if ($urandom_range(99) < 25) begin
               s = mk(OP_LOAD, 6'($urandom_range(63)), 3'($urandom_range(7)), rand_q(),
                      $urandom(), $urandom(), $urandom(), $urandom(),
                      17'($urandom_range(17'h1FFFF)), 1'($urandom_range(1)), 0, 0,0,0);
               drive_item(s);
               n++;
            end else begin
               // one vertex: a few influences, last one closes it
               k = $urandom_range(1, 4);
               for (int j = 0; j < k; j++) begin
                  s = mk(OP_BLEND, pick_bone(), 3'($urandom_range(7)), $urandom(),
                         rand_q(), rand_q(), ($urandom_range(2) == 0) ? rand_q() : 32'h0,
                         ($urandom_range(2) == 0) ? rand_q() : 32'h0,
                         ($urandom_range(9) == 0) ? 17'($urandom_range(65537, 131071))
                                                  : 17'($urandom_range(0, 65536)),
                         (j == k - 1), 0, 0,0,0);
                  drive_item(s);
                  n++;
               end
            end
         end
         drain();
      end
      calm = 1'b0;

      if (err_count == 0 && pending_pos.size() == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end
endmodule
`default_nettype wire
